// ----- rtl/tttr_pkg.sv -----
// shared types and constants for the time-tagged record decoder
`default_nettype none

package tttr_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CHAN_W  = 6;
    localparam int unsigned DELAY_W = 15;
    localparam int unsigned COUNT_W = 28;
    localparam int unsigned CORR_W  = 64;
    localparam int unsigned FMT_W   = 2;

    // register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_SINGLE = 1'd1;

    // overflow periods
    localparam logic [CORR_W-1:0] WIDE_T3_PERIOD     = 64'd1024;
    localparam logic [CORR_W-1:0] WIDE_T2_PERIOD_OLD = 64'd33552000;
    localparam logic [CORR_W-1:0] NARROW_T3_PERIOD   = 64'd65536;
    localparam logic [CORR_W-1:0] NARROW_T2_PERIOD   = 64'd210698240;

    // shifts that stand for multiplication by the power-of-two periods
    localparam int unsigned WIDE_T3_SHIFT = 10;
    localparam int unsigned WIDE_T2_SHIFT = 25;

    localparam logic [CHAN_W-1:0] WIDE_OVF_CHANNEL = 6'd63;

    typedef enum logic [FMT_W-1:0] {
        FMT_WIDE_T3   = 2'd0,
        FMT_NARROW_T3 = 2'd1,
        FMT_WIDE_T2   = 2'd2,
        FMT_NARROW_T2 = 2'd3
    } fmt_t;

    // split fields of one record plus its correction step
    typedef struct packed {
        logic               is_special;
        logic               is_marker;
        logic               is_overflow;
        logic [CHAN_W-1:0]  channel_number;
        logic [DELAY_W-1:0] delay_time;
        logic [COUNT_W-1:0] sync_or_timetag;
        logic [CORR_W-1:0]  add_amount;
    } split_t;

endpackage

`default_nettype wire

// ----- rtl/tttr_field_split.sv -----
// record field split and overflow classification, purely combinational
`default_nettype none

module tttr_field_split (
    input  wire logic [tttr_pkg::WORD_W-1:0] word,
    input  wire tttr_pkg::fmt_t              fmt,
    input  wire logic                        legacy,
    output tttr_pkg::split_t                 split
);

    logic                                wide_special;
    logic                                narrow_special;
    logic [tttr_pkg::CHAN_W-1:0]         wide_chan;
    logic [9:0]                          wide_t3_count;
    logic [24:0]                         wide_t2_count;
    logic [11:0]                         narrow_delay;
    logic                                ovf;

    assign wide_special   = word[31];
    assign narrow_special = &word[31:28];
    assign wide_chan      = word[30:25];
    assign wide_t3_count  = word[9:0];
    assign wide_t2_count  = word[24:0];
    assign narrow_delay   = word[27:16];

    always_comb
    begin
        split = '0;
        ovf   = 1'b0;
        unique case (fmt)
            tttr_pkg::FMT_WIDE_T3:
            begin
                split.is_special      = wide_special;
                split.channel_number  = wide_chan;
                split.delay_time      = word[24:10];
                split.sync_or_timetag = tttr_pkg::COUNT_W'(wide_t3_count);
                ovf = wide_special && (wide_chan == tttr_pkg::WIDE_OVF_CHANNEL);
                split.add_amount = legacy ? tttr_pkg::WIDE_T3_PERIOD
                    : (tttr_pkg::CORR_W'(wide_t3_count) << tttr_pkg::WIDE_T3_SHIFT);
            end
            tttr_pkg::FMT_NARROW_T3:
            begin
                split.is_special      = narrow_special;
                split.channel_number  = tttr_pkg::CHAN_W'(word[31:28]);
                split.delay_time      = tttr_pkg::DELAY_W'(narrow_delay);
                split.sync_or_timetag = tttr_pkg::COUNT_W'(word[15:0]);
                ovf = narrow_special && (narrow_delay == '0);
                split.add_amount = tttr_pkg::NARROW_T3_PERIOD;
            end
            tttr_pkg::FMT_WIDE_T2:
            begin
                split.is_special      = wide_special;
                split.channel_number  = wide_chan;
                split.sync_or_timetag = tttr_pkg::COUNT_W'(wide_t2_count);
                ovf = wide_special && (wide_chan == tttr_pkg::WIDE_OVF_CHANNEL);
                split.add_amount = legacy ? tttr_pkg::WIDE_T2_PERIOD_OLD
                    : (tttr_pkg::CORR_W'(wide_t2_count) << tttr_pkg::WIDE_T2_SHIFT);
            end
            tttr_pkg::FMT_NARROW_T2:
            begin
                split.is_special      = narrow_special;
                split.channel_number  = tttr_pkg::CHAN_W'(word[31:28]);
                split.sync_or_timetag = word[27:0];
                ovf = narrow_special && (word[3:0] == 4'd0);
                split.add_amount = tttr_pkg::NARROW_T2_PERIOD;
            end
            default:
            begin
                split = '0;
                ovf   = 1'b0;
            end
        endcase
        split.is_overflow = ovf;
        split.is_marker   = split.is_special && !ovf;
    end

endmodule

`default_nettype wire

// ----- rtl/tttr_accumulator.sv -----
// 64-bit wrapping overflow correction register
`default_nettype none

module tttr_accumulator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic                        is_overflow,
    input  wire logic [tttr_pkg::CORR_W-1:0] add_amount,
    output logic      [tttr_pkg::CORR_W-1:0] total
);

    logic [tttr_pkg::CORR_W-1:0] acc_reg;
    logic [tttr_pkg::CORR_W-1:0] acc_next;

    // total after this record, wraps modulo 2^64
    assign total    = is_overflow ? (acc_reg + add_amount) : acc_reg;
    assign acc_next = advance ? total : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tttr_record_overflow_decoder.sv -----
// top level: time-tagged record decoder with overflow correction
// an accepted item passes through the input register, then the result register, to m_tvalid
// throughput: one item per cycle while m_tready stays high, set by the single split and 64-bit add stage
// s_tready stays high while the result register drains or is empty
// reset clears the valid flags, the correction total and both config registers
`default_nettype none

module tttr_record_overflow_decoder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // config write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tttr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tttr_pkg::FMT_W-1:0]     cfg_data,
    // input records
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [31:0]                    s_tdata,  // record_word
    // results
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [5:0] channel_number, [20:6] delay_time, [48:21] sync_or_timetag,
    // [112:49] correction_total, [119:113] zero
    output logic      [119:0]                   m_tdata,
    // [0] is_special, [1] is_marker, [2] is_overflow
    output logic      [2:0]                     m_tuser
);

    // config registers
    tttr_pkg::fmt_t fmt_reg;
    tttr_pkg::fmt_t fmt_next;
    logic           legacy_reg;
    logic           legacy_next;

    // input register stage
    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [tttr_pkg::WORD_W-1:0]   in_word_reg;
    logic [tttr_pkg::WORD_W-1:0]   in_word_next;

    // result register stage
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [119:0]                  out_data_reg;
    logic [119:0]                  out_data_next;
    logic [2:0]                    out_user_reg;
    logic [2:0]                    out_user_next;

    tttr_pkg::split_t              split;
    logic [tttr_pkg::CORR_W-1:0]   corr_total;
    logic                          advance;
    logic                          in_take;

    // config writes are taken at any time; block is idle by contract
    assign cfg_ready = 1'b1;

    // item in the input register moves on when the result register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    tttr_field_split u_split (
        .word   (in_word_reg),
        .fmt    (fmt_reg),
        .legacy (legacy_reg),
        .split  (split)
    );

    tttr_accumulator u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .is_overflow (split.is_overflow),
        .add_amount  (split.add_amount),
        .total       (corr_total)
    );

    always_comb
    begin
        fmt_next    = fmt_reg;
        legacy_next = legacy_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tttr_pkg::CFG_RECORD_FORMAT: fmt_next    = tttr_pkg::fmt_t'(cfg_data);
                tttr_pkg::CFG_LEGACY_SINGLE: legacy_next = cfg_data[0];
                default:                     fmt_next    = fmt_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_word_next  = in_word_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            in_word_next  = s_tdata;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {7'd0, corr_total, split.sync_or_timetag,
                              split.delay_time, split.channel_number};
            out_user_next  = {split.is_overflow, split.is_marker, split.is_special};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= tttr_pkg::FMT_WIDE_T3;
            legacy_reg    <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fmt_reg       <= fmt_next;
            legacy_reg    <= legacy_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        in_word_reg  <= in_word_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

// ----- rtl/tttr_checker.sv -----
// port-level checks for the record decoder, bound to the top level
`default_nettype none

module tttr_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [119:0]                   m_tdata,
    input wire logic [2:0]                     m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // marker and overflow never together
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[1] && m_tuser[2]))
        else $error("marker and overflow both set");

    // marker or overflow only on special records
    a_kind_special: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1] || m_tuser[2]) |-> m_tuser[0])
        else $error("marker or overflow on a non-special item");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tttr_record_overflow_decoder tttr_checker u_checker (.*);

`default_nettype wire

// ----- dv/tttr_record_overflow_decoder_tb.sv -----
// self-checking testbench for the time-tagged record decoder with overflow correction
module tttr_record_overflow_decoder_tb;

    import tttr_pkg::*;

    // wide T2 period for current devices, not needed by the package
    localparam logic [CORR_W-1:0] WIDE_T2_PERIOD_NEW = 64'd33554432;

    // item counts and timing limits
    localparam int RANDOM_ITEMS    = 1600;
    localparam int BIG_ADD_ITEMS   = 64;      // max-count overflows, large steps in the total
    localparam int LONG_HOLD       = 300;     // long receiver stall to back up the pipe
    localparam int SETTLE_CYCLES   = 4;       // time for the input and result registers to settle, plus margin
    localparam int WATCHDOG_LIMIT  = 2000;

    // one decoded record as the block reports it
    typedef struct packed {
        logic               is_special;
        logic               is_marker;
        logic               is_overflow;
        logic [CHAN_W-1:0]  channel_number;
        logic [DELAY_W-1:0] delay_time;
        logic [COUNT_W-1:0] sync_or_timetag;
        logic [CORR_W-1:0]  correction_total;
    } decoded_t;

    // directed stimulus row: setting, record and, where obvious, the typed-in result
    typedef struct packed {
        fmt_t     fmt;
        logic     legacy;
        logic [31:0] word;
        logic     typed;
        decoded_t want;
    } stim_row_t;

    localparam decoded_t NO_WANT = '0;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FMT_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [119:0]         m_tdata;
    logic [2:0]           m_tuser;

    // predictor state: its own copy of the registers and the correction total
    fmt_t        fmt_setting = FMT_WIDE_T3;
    logic        legacy_setting = 1'b0;
    logic [63:0] corr_model = '0;

    decoded_t pending_results [$];
    int       error_count = 0;
    int       quiet_cycles = 0;
    int       stall_left = 0;
    bit       no_idle = 1'b0;        // phase with no gaps on either side
    bit       long_hold_req = 1'b0;  // asks the receiver for one long stall

    // directed part: extremes, every layout and legacy setting, each special case;
    // only the first rows after reset carry a typed-in result
    stim_row_t stim_table [0:23] = '{
        // after reset: all-zero record in wide T3
        '{FMT_WIDE_T3,   1'b0, 32'h0000_0000, 1'b1,
          '{1'b0, 1'b0, 1'b0, 6'd0, 15'd0, 28'd0, 64'd0}},
        // all ones: overflow with the largest count, 1023 * 1024
        '{FMT_WIDE_T3,   1'b0, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 1'b0, 1'b1, 6'd63, 15'd32767, 28'd1023, 64'd1047552}},
        // special bit clear: fields still split, total unchanged
        '{FMT_WIDE_T3,   1'b0, 32'h7FFF_FFFF, 1'b1,
          '{1'b0, 1'b0, 1'b0, 6'd63, 15'd32767, 28'd1023, 64'd1047552}},
        // overflow with a zero count: flagged, nothing added
        '{FMT_WIDE_T3,   1'b0, 32'hFE00_0000, 1'b1,
          '{1'b1, 1'b0, 1'b1, 6'd63, 15'd0, 28'd0, 64'd1047552}},
        // marker on channel 31
        '{FMT_WIDE_T3,   1'b0, 32'hBFFF_FFFF, 1'b1,
          '{1'b1, 1'b1, 1'b0, 6'd31, 15'd32767, 28'd1023, 64'd1047552}},
        '{FMT_WIDE_T3,   1'b0, 32'h8000_0001, 1'b0, NO_WANT},
        // legacy wide T3: one period whatever the count
        '{FMT_WIDE_T3,   1'b1, 32'hFE00_03FF, 1'b0, NO_WANT},
        '{FMT_WIDE_T3,   1'b1, 32'h1234_5678, 1'b0, NO_WANT},
        // narrow T3: overflow when delay is zero, else marker
        '{FMT_NARROW_T3, 1'b0, 32'hF000_0000, 1'b0, NO_WANT},
        '{FMT_NARROW_T3, 1'b0, 32'hF001_0000, 1'b0, NO_WANT},
        '{FMT_NARROW_T3, 1'b0, 32'hEFFF_FFFF, 1'b0, NO_WANT},
        '{FMT_NARROW_T3, 1'b0, 32'hFFFF_FFFF, 1'b0, NO_WANT},
        // legacy flag has no effect in narrow layouts
        '{FMT_NARROW_T3, 1'b1, 32'hF000_ABCD, 1'b0, NO_WANT},
        // wide T2: count times 2^25, zero count, markers on channels 0 and 62
        '{FMT_WIDE_T2,   1'b0, 32'hFFFF_FFFF, 1'b0, NO_WANT},
        '{FMT_WIDE_T2,   1'b0, 32'hFE00_0000, 1'b0, NO_WANT},
        '{FMT_WIDE_T2,   1'b0, 32'h81FF_FFFF, 1'b0, NO_WANT},
        '{FMT_WIDE_T2,   1'b0, 32'h0000_0000, 1'b0, NO_WANT},
        '{FMT_WIDE_T2,   1'b1, 32'hFE00_0005, 1'b0, NO_WANT},
        '{FMT_WIDE_T2,   1'b1, 32'hFDFF_FFFF, 1'b0, NO_WANT},
        // narrow T2: overflow when the low nibble is zero
        '{FMT_NARROW_T2, 1'b0, 32'hF000_0000, 1'b0, NO_WANT},
        '{FMT_NARROW_T2, 1'b0, 32'hFFFF_FFF0, 1'b0, NO_WANT},
        '{FMT_NARROW_T2, 1'b0, 32'hFFFF_FFFF, 1'b0, NO_WANT},
        '{FMT_NARROW_T2, 1'b0, 32'h0FFF_FFFF, 1'b0, NO_WANT},
        '{FMT_NARROW_T2, 1'b1, 32'hF123_4560, 1'b0, NO_WANT}
    };

    tttr_record_overflow_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // splits one record under the current setting and advances the correction total
    function automatic decoded_t decode_record(input logic [31:0] w);
        logic               sp;
        logic               ovf;
        logic [CHAN_W-1:0]  ch;
        logic [DELAY_W-1:0] dly;
        logic [COUNT_W-1:0] cnt;
        logic [CORR_W-1:0]  add;
        decoded_t           r;
        sp  = 1'b0;
        ovf = 1'b0;
        ch  = '0;
        dly = '0;
        cnt = '0;
        add = '0;
        case (fmt_setting)
            FMT_WIDE_T3:
            begin
                sp  = w[31];
                ch  = w[30:25];
                dly = w[24:10];
                cnt = {18'd0, w[9:0]};
                if (sp && ch == 6'd63)
                begin
                    ovf = 1'b1;
                    add = legacy_setting ? WIDE_T3_PERIOD : 64'(w[9:0]) * WIDE_T3_PERIOD;
                end
            end
            FMT_NARROW_T3:
            begin
                sp  = &w[31:28];
                ch  = {2'b00, w[31:28]};
                dly = {3'd0, w[27:16]};
                cnt = {12'd0, w[15:0]};
                if (sp && w[27:16] == 12'd0)
                begin
                    ovf = 1'b1;
                    add = NARROW_T3_PERIOD;
                end
            end
            FMT_WIDE_T2:
            begin
                sp  = w[31];
                ch  = w[30:25];
                cnt = {3'd0, w[24:0]};
                if (sp && ch == 6'd63)
                begin
                    ovf = 1'b1;
                    add = legacy_setting ? WIDE_T2_PERIOD_OLD
                                         : 64'(w[24:0]) * WIDE_T2_PERIOD_NEW;
                end
            end
            default:
            begin
                sp  = &w[31:28];
                ch  = {2'b00, w[31:28]};
                cnt = w[27:0];
                if (sp && w[3:0] == 4'd0)
                begin
                    ovf = 1'b1;
                    add = NARROW_T2_PERIOD;
                end
            end
        endcase
        if (ovf)
            corr_model = corr_model + add;
        r = '{sp, sp && !ovf, ovf, ch, dly, cnt, corr_model};
        return r;
    endfunction

    // stall or gap length: drawn mostly from the shortest range, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(10, 40);
    endfunction

    // random record for the current layout: mostly well-formed overflows,
    // markers and plain photons, the rest raw noise
    function automatic logic [31:0] shape_record();
        int          pick;
        logic [31:0] w;
        logic [5:0]  ch;
        logic [11:0] dl;
        logic [3:0]  nib;
        logic [24:0] low25;
        pick  = $urandom_range(0, 99);
        w     = $urandom;
        // small counts now and then, zero among them
        low25 = ($urandom_range(0, 3) == 0) ? 25'($urandom_range(0, 3)) : w[24:0];
        if (pick < 35)
            return w;
        case (fmt_setting)
            FMT_WIDE_T3, FMT_WIDE_T2:
            begin
                if (pick < 60)
                    w = {1'b1, 6'h3F, low25};
                else if (pick < 80)
                begin
                    ch = 6'($urandom_range(0, 62));
                    w  = {1'b1, ch, w[24:0]};
                end
                else
                    w[31] = 1'b0;
            end
            FMT_NARROW_T3:
            begin
                if (pick < 60)
                    w = {4'hF, 12'h000, w[15:0]};
                else if (pick < 80)
                begin
                    dl = 12'($urandom_range(1, 4095));
                    w  = {4'hF, dl, w[15:0]};
                end
                else
                begin
                    nib = 4'($urandom_range(0, 14));
                    w[31:28] = nib;
                end
            end
            default:
            begin
                if (pick < 60)
                    w = {4'hF, w[27:4], 4'h0};
                else if (pick < 80)
                begin
                    nib = 4'($urandom_range(1, 15));
                    w   = {4'hF, w[27:4], nib};
                end
                else
                begin
                    nib = 4'($urandom_range(0, 14));
                    w[31:28] = nib;
                end
            end
        endcase
        return w;
    endfunction

    // offers one record after an optional gap; entered and left at a falling edge
    task automatic send_record(input logic [31:0] word, input logic typed,
                               input decoded_t want);
        int       gap;
        decoded_t predicted;
        gap = (!no_idle && $urandom_range(0, 99) < 35) ? gap_length() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        // the predictor runs on every accepted record to keep its total in step
        predicted = decode_record(word);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // drop the input, let every pending result drain, then allow for the latency
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one register write; cfg_valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FMT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_RECORD_FORMAT: fmt_setting = fmt_t'(data);
            CFG_LEGACY_SINGLE: legacy_setting = data[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // both registers are written at every change of setting, only once idle
    task automatic apply_setting(input fmt_t fmt, input logic legacy);
        wait_idle();
        write_reg(CFG_RECORD_FORMAT, FMT_W'(fmt));
        write_reg(CFG_LEGACY_SINGLE, {1'b0, legacy});
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request so the
    // block fills and stalls its input while the sender keeps offering
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 99) < 25)
            begin
                stall_left = gap_length() - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // each accepted result against the oldest expectation, field by field
    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no record pending: tdata %0h tuser %0h", m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("is_special", 64'(want.is_special), 64'(m_tuser[0]));
                check_field("is_marker", 64'(want.is_marker), 64'(m_tuser[1]));
                check_field("is_overflow", 64'(want.is_overflow), 64'(m_tuser[2]));
                check_field("channel_number", 64'(want.channel_number),
                            64'(m_tdata[5:0]));
                check_field("delay_time", 64'(want.delay_time), 64'(m_tdata[20:6]));
                check_field("sync_or_timetag", 64'(want.sync_or_timetag),
                            64'(m_tdata[48:21]));
                check_field("correction_total", want.correction_total, m_tdata[112:49]);
            end
        end
    end

    // watchdog: too long with no item moving on any channel ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int   i;
        int   n;
        int   phase;
        int   total;
        fmt_t f;
        logic l;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table; settings change only between rows, with the block idle
        for (i = 0; i < $size(stim_table); i++)
        begin
            if (i == 0 || stim_table[i].fmt != fmt_setting ||
                stim_table[i].legacy != legacy_setting)
                apply_setting(stim_table[i].fmt, stim_table[i].legacy);
            send_record(stim_table[i].word, stim_table[i].typed, stim_table[i].want);
        end

        // back-to-back max-count wide T2 overflows, large steps into the upper bits
        apply_setting(FMT_WIDE_T2, 1'b0);
        no_idle = 1'b1;
        repeat (BIG_ADD_ITEMS) send_record(32'hFFFF_FFFF, 1'b0, NO_WANT);
        no_idle = 1'b0;

        // random phases: all eight settings in turn first, then random ones
        phase = 0;
        total = 0;
        while (total < RANDOM_ITEMS)
        begin
            if (phase < 8)
            begin
                f = fmt_t'(phase % 4);
                l = 1'((phase / 4) % 2);
            end
            else
            begin
                f = fmt_t'($urandom_range(0, 3));
                l = 1'($urandom_range(0, 1));
            end
            apply_setting(f, l);
            no_idle = (phase == 2) || (phase > 8 && $urandom_range(0, 4) == 0);
            // one long receiver hold-off while the sender streams without gaps
            if (phase == 2)
                long_hold_req = 1'b1;
            n = $urandom_range(60, 140);
            repeat (n) send_record(shape_record(), 1'b0, NO_WANT);
            total += n;
            phase++;
        end

        no_idle = 1'b0;
        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
